// File: rtl/dmaf_pkg.sv
// shared types and command codes for the additive distance fill block
package dmaf_pkg;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_FILL = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [30:0] dist_value;
    logic        dist_missing;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic               out_valid;
    logic               out_last;
    logic               fill_done;
  } out_t;

endpackage

// File: rtl/distance_matrix_additive_fill.sv
// top level: condensed distance load, four-point missing fill sweeps, matrix readout
//
// channel   | direction | handshake                     | payload
// ----------+-----------+-------------------------------+----------------------------
// command   | in        | start & !busy                 | cmd (in_t)
// result    | out       | strobe, one cycle, no stall   | result (out_t)
// config    | in        | cfg_valid & cfg_ready         | cfg_data (matrix_size)
//
// load: busy after the beat through S_LD_W1 and S_LD_W2, one per symmetric cell write
// read: busy in S_RD_A (address) and S_RD_D (memory data); strobe in the cycle after
// fill: per sweep each pair is read; a missing pair walks every k and l, its cells read
//   through the single read port of the matrix memory; sweeps repeat until none changes
// config: ready only while idle with no start; a size beat keeps the block busy while
//   the load and read positions are walked for the new size
// reset clears control state only; the matrix memory holds nothing until loaded
// the receiver cannot stall, so a result beat is never held
module distance_matrix_additive_fill import dmaf_pkg::*; #(
  parameter int MAX_TAXA   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  in_t        cmd,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data,
  output logic       strobe,
  output out_t       result
);

  localparam int W  = VALUE_BITS;
  localparam int IW = $clog2(MAX_TAXA);
  localparam int NW = IW + 1;
  localparam int AW = 2 * IW;
  localparam int PW = $clog2(MAX_TAXA * MAX_TAXA + 1);
  localparam int EW = (W > 32) ? W : 32;
  localparam logic [48:0] VMAX_X = (49'd1 << (W - 1)) - 49'd1;

  typedef enum logic [4:0] {
    S_IDLE, S_LD_W1, S_LD_W2, S_RD_A, S_RD_D,
    S_P_RD, S_P_CHK, S_K_IK, S_K_JK, S_K_CHK,
    S_L_KL, S_L_IL, S_L_JL, S_L_CAP,
    S_DRAIN1, S_DRAIN2, S_F_W1, S_F_W2,
    S_DEC_INIT, S_DEC_RUN
  } state_t;

  state_t state;

  // matrix memory: valid bit on top of the value
  logic [W:0]    mem [0:(1<<AW)-1];
  logic [W:0]    rd_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [W:0]    wr_data;
  logic          wr_en, diag_q;

  logic [6:0]    matrix_size;
  logic [NW-1:0] n;
  logic [PW-1:0] pairs, total;

  logic [PW-1:0] ld_ptr, rd_ptr;
  logic [IW-1:0] ld_pi, ld_pj, rd_r, rd_c;
  logic [IW-1:0] ld_i, ld_j;
  logic [W-1:0]  ld_val;
  logic          ld_ok;
  logic signed [W-1:0] largest;

  logic [IW-1:0] fi, fj, fk, fl;
  logic signed [W-1:0] best, dik, djk, dkl, dil;
  logic          found, changed, okik, okkl, okil;

  // load and read positions, restarting when a pointer is beyond the current size
  logic          ld_wrap, rd_wrap;
  logic [PW-1:0] ld_p_eff, rd_p_eff;
  logic [IW-1:0] ld_i_eff, ld_j_eff, rd_r_eff, rd_c_eff;
  logic [48:0]   v_ext;
  logic [W-1:0]  v_sat;

  logic          rd_ok;
  logic signed [W-1:0] rd_val;
  logic signed [EW-1:0] rd_ext;

  logic          k_last, l_last, j_last, i_last, q_fire, q_valid;
  logic signed [W-1:0] q_m;

  // position walk after a size change: rows of the triangle and of the square
  logic [PW-1:0] dec_lrem, dec_rrem;
  logic [IW-1:0] dec_li, dec_ri;
  logic [NW-1:0] dec_row;
  logic          dec_lmore, dec_rmore;

  assign n = (matrix_size < 7'd2) ? NW'(2) :
             (32'(matrix_size) > 32'(MAX_TAXA)) ? NW'(MAX_TAXA) : NW'(matrix_size);
  assign total = PW'({{NW{1'b0}}, n} * {{NW{1'b0}}, n});
  assign pairs = PW'(({{NW{1'b0}}, n} * {{NW{1'b0}}, n - NW'(1)}) >> 1);

  assign ld_wrap  = (ld_ptr >= pairs);
  assign ld_p_eff = ld_wrap ? '0 : ld_ptr;
  assign ld_i_eff = ld_wrap ? '0 : ld_pi;
  assign ld_j_eff = ld_wrap ? IW'(1) : ld_pj;
  assign rd_wrap  = (rd_ptr >= total);
  assign rd_p_eff = rd_wrap ? '0 : rd_ptr;
  assign rd_r_eff = rd_wrap ? '0 : rd_r;
  assign rd_c_eff = rd_wrap ? '0 : rd_c;

  // a pointer past the new size restarts anyway, so its walk stops at once
  assign dec_lmore = (ld_ptr < pairs) && (dec_lrem >= PW'(dec_row));
  assign dec_rmore = (rd_ptr < total) && (dec_rrem >= PW'(n));

  assign v_ext = 49'(cmd.dist_value);
  assign v_sat = (v_ext > VMAX_X) ? VMAX_X[W-1:0] : v_ext[W-1:0];

  // diagonal always reads zero and valid
  assign rd_ok  = diag_q ? 1'b1 : rd_data[W];
  assign rd_val = diag_q ? '0 : rd_data[W-1:0];
  assign rd_ext = EW'(rd_val);

  assign k_last = (({1'b0, fk} + NW'(1)) == n);
  assign l_last = (({1'b0, fl} + NW'(1)) == n);
  assign j_last = (({1'b0, fj} + NW'(1)) == n);
  assign i_last = (({1'b0, fi} + NW'(2)) == n);

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;

  always_comb begin
    unique case (state)
      S_RD_A:  rd_addr = {rd_r, rd_c};
      S_P_RD:  rd_addr = {fi, fj};
      S_K_IK:  rd_addr = {fi, fk};
      S_K_JK:  rd_addr = {fj, fk};
      S_L_KL:  rd_addr = {fk, fl};
      S_L_IL:  rd_addr = {fi, fl};
      S_L_JL:  rd_addr = {fj, fl};
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state)
      S_LD_W1: begin wr_en = 1'b1; wr_addr = {ld_i, ld_j}; wr_data = {ld_ok, ld_val}; end
      S_LD_W2: begin wr_en = 1'b1; wr_addr = {ld_j, ld_i}; wr_data = {ld_ok, ld_val}; end
      S_F_W1:  begin wr_en = found; wr_addr = {fi, fj}; wr_data = {1'b1, best}; end
      S_F_W2:  begin wr_en = found; wr_addr = {fj, fi}; wr_data = {1'b1, best}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
    diag_q  <= (rd_addr[AW-1:IW] == rd_addr[IW-1:0]);
  end

  // quartet fires once the last of its five cells is in
  assign q_fire = (state == S_L_CAP) && okkl && okil && rd_ok && (fk != fl);

  dmaf_quartet #(.VALUE_BITS(VALUE_BITS)) u_quartet (
    .clk     (clk),
    .rst     (rst),
    .fire    (q_fire),
    .dik     (dik),
    .djl     (rd_val),
    .dil     (dil),
    .djk     (djk),
    .dkl     (dkl),
    .m_valid (q_valid),
    .m       (q_m)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      strobe      <= 1'b0;
      matrix_size <= 7'd4;
      ld_ptr      <= '0;
      ld_pi       <= '0;
      ld_pj       <= IW'(1);
      rd_ptr      <= '0;
      rd_r        <= '0;
      rd_c        <= '0;
      largest     <= '0;
      changed     <= 1'b0;
      found       <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cfg_valid && cfg_ready) matrix_size <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            priority case (cmd.action)
              ACT_LOAD: begin
                ld_i   <= ld_i_eff;
                ld_j   <= ld_j_eff;
                ld_val <= v_sat;
                ld_ok  <= !cmd.dist_missing;
                if (ld_p_eff == '0) begin
                  largest <= cmd.dist_missing ? '0 : $signed(v_sat);
                end else if (!cmd.dist_missing && ($signed(v_sat) > largest)) begin
                  largest <= $signed(v_sat);
                end
                // advance along the upper triangle, wrapping after the last pair
                if ((ld_p_eff + PW'(1)) >= pairs) begin
                  ld_ptr <= '0;
                  ld_pi  <= '0;
                  ld_pj  <= IW'(1);
                end else if (({1'b0, ld_j_eff} + NW'(1)) == n) begin
                  ld_ptr <= ld_p_eff + PW'(1);
                  ld_pi  <= ld_i_eff + IW'(1);
                  ld_pj  <= ld_i_eff + IW'(2);
                end else begin
                  ld_ptr <= ld_p_eff + PW'(1);
                  ld_pi  <= ld_i_eff;
                  ld_pj  <= ld_j_eff + IW'(1);
                end
                state <= S_LD_W1;
              end
              ACT_FILL: begin
                fi      <= '0;
                fj      <= IW'(1);
                changed <= 1'b0;
                state   <= S_P_RD;
              end
              ACT_READ: begin
                rd_r          <= rd_r_eff;
                rd_c          <= rd_c_eff;
                rd_ptr        <= rd_p_eff;
                result.out_last <= (rd_p_eff == total - PW'(1));
                state         <= S_RD_A;
              end
              default: ;
            endcase
          end else if (cfg_valid && cfg_ready) begin
            state <= S_DEC_INIT;
          end
        end
        S_DEC_INIT: begin
          dec_lrem <= ld_ptr;
          dec_rrem <= rd_ptr;
          dec_li   <= '0;
          dec_ri   <= '0;
          dec_row  <= n - NW'(1);
          state    <= S_DEC_RUN;
        end
        S_DEC_RUN: begin
          // one row of each walk per cycle
          if (dec_lmore) begin
            dec_lrem <= dec_lrem - PW'(dec_row);
            dec_li   <= dec_li + IW'(1);
            dec_row  <= dec_row - NW'(1);
          end
          if (dec_rmore) begin
            dec_rrem <= dec_rrem - PW'(n);
            dec_ri   <= dec_ri + IW'(1);
          end
          if (!dec_lmore && !dec_rmore) begin
            ld_pi <= dec_li;
            ld_pj <= dec_li + IW'(1) + dec_lrem[IW-1:0];
            rd_r  <= dec_ri;
            rd_c  <= dec_rrem[IW-1:0];
            state <= S_IDLE;
          end
        end
        S_LD_W1: state <= S_LD_W2;
        S_LD_W2: state <= S_IDLE;
        S_RD_A: begin
          if ((rd_ptr + PW'(1)) >= total) begin
            rd_ptr <= '0;
            rd_r   <= '0;
            rd_c   <= '0;
          end else if (({1'b0, rd_c} + NW'(1)) == n) begin
            rd_ptr <= rd_ptr + PW'(1);
            rd_r   <= rd_r + IW'(1);
            rd_c   <= '0;
          end else begin
            rd_ptr <= rd_ptr + PW'(1);
            rd_c   <= rd_c + IW'(1);
          end
          state <= S_RD_D;
        end
        S_RD_D: begin
          result.out_value <= rd_ext[31:0];
          result.out_valid <= rd_ok;
          result.fill_done <= 1'b0;
          strobe           <= 1'b1;
          state            <= S_IDLE;
        end
        S_P_RD: state <= S_P_CHK;
        S_P_CHK: begin
          if (rd_ok) begin
            state <= S_F_W2;  // known pair: no write, straight to the next-pair step
            found <= 1'b0;
          end else begin
            best  <= largest;
            found <= 1'b0;
            fk    <= '0;
            state <= S_K_IK;
          end
        end
        S_K_IK: state <= S_K_JK;
        S_K_JK: begin
          dik   <= rd_val;
          okik  <= rd_ok;
          state <= S_K_CHK;
        end
        S_K_CHK: begin
          if (okik && rd_ok) begin
            djk   <= rd_val;
            fl    <= '0;
            state <= S_L_KL;
          end else if (k_last) begin
            state <= S_DRAIN1;
          end else begin
            fk    <= fk + IW'(1);
            state <= S_K_IK;
          end
        end
        S_L_KL: state <= S_L_IL;
        S_L_IL: begin
          dkl   <= rd_val;
          okkl  <= rd_ok;
          state <= S_L_JL;
        end
        S_L_JL: begin
          dil   <= rd_val;
          okil  <= rd_ok;
          state <= S_L_CAP;
        end
        S_L_CAP: begin
          if (q_fire) found <= 1'b1;
          if (!l_last) begin
            fl    <= fl + IW'(1);
            state <= S_L_KL;
          end else if (k_last) begin
            state <= S_DRAIN1;
          end else begin
            fk    <= fk + IW'(1);
            state <= S_K_IK;
          end
        end
        S_DRAIN1: state <= S_DRAIN2;
        S_DRAIN2: state <= S_F_W1;
        S_F_W1: begin
          if (found) begin
            changed <= 1'b1;
            state   <= S_F_W2;
          end else begin
            state <= S_F_W2;
          end
        end
        S_F_W2: begin
          // next pair in row order, or end of sweep
          if (j_last) begin
            if (i_last) begin
              if (changed) begin
                changed <= 1'b0;
                fi      <= '0;
                fj      <= IW'(1);
                state   <= S_P_RD;
              end else begin
                rd_ptr           <= '0;
                rd_r             <= '0;
                rd_c             <= '0;
                result.out_value <= '0;
                result.out_valid <= 1'b0;
                result.out_last  <= 1'b0;
                result.fill_done <= 1'b1;
                strobe           <= 1'b1;
                state            <= S_IDLE;
              end
            end else begin
              fi    <= fi + IW'(1);
              fj    <= fi + IW'(2);
              state <= S_P_RD;
            end
          end else begin
            fj    <= fj + IW'(1);
            state <= S_P_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (q_valid && (q_m < best)) best <= q_m;
    end
  end

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy)) else $error("result beat without a command in flight");

  a_fill_clean: assert property (@(posedge clk) disable iff (rst)
    strobe && result.fill_done |-> !result.out_valid && !result.out_last)
    else $error("fill answer carries matrix fields");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !wr_en) else $error("memory write while idle");

  a_quartet_busy: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> busy) else $error("quartet result outside a fill");

  // the mirror write only follows the write of a filled pair
  a_no_skip_mirror: assert property (@(posedge clk) disable iff (rst)
    (state == S_F_W2) && wr_en |-> $past(state) == S_F_W1)
    else $error("mirror write without a filled value");

endmodule

// File: rtl/dmaf_quartet.sv
// two-stage quartet estimate: max(dik+djl, dil+djk) - dkl with saturation
module dmaf_quartet import dmaf_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic signed [VALUE_BITS-1:0] dik,
  input  logic signed [VALUE_BITS-1:0] djl,
  input  logic signed [VALUE_BITS-1:0] dil,
  input  logic signed [VALUE_BITS-1:0] djk,
  input  logic signed [VALUE_BITS-1:0] dkl,
  output logic                         m_valid,
  output logic signed [VALUE_BITS-1:0] m
);

  localparam int W = VALUE_BITS;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  logic signed [W:0]   sum_a, sum_b, diff;
  logic signed [W-1:0] sat_a, sat_b, a, b, dkl_q, mx, sat_m;
  logic                v1;

  // one extra bit catches the overflow, sign of the wide result picks the rail
  assign sum_a = {dik[W-1], dik} + {djl[W-1], djl};
  assign sum_b = {dil[W-1], dil} + {djk[W-1], djk};
  assign sat_a = (sum_a[W] != sum_a[W-1]) ? (sum_a[W] ? VMIN : VMAX) : sum_a[W-1:0];
  assign sat_b = (sum_b[W] != sum_b[W-1]) ? (sum_b[W] ? VMIN : VMAX) : sum_b[W-1:0];

  assign mx    = (a > b) ? a : b;
  assign diff  = {mx[W-1], mx} - {dkl_q[W-1], dkl_q};
  assign sat_m = (diff[W] != diff[W-1]) ? (diff[W] ? VMIN : VMAX) : diff[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      v1      <= fire;
      m_valid <= v1;
    end
    a     <= sat_a;
    b     <= sat_b;
    dkl_q <= dkl;
    m     <= sat_m;
  end

endmodule

// File: test/tb_top.sv
// self-checking testbench for the additive distance fill block: queued command beats, scoreboard
module tb_top;
  import dmaf_pkg::*;

  localparam int TAXA_CAP  = 64;
  localparam longint VMAX  = 64'sd2147483647;
  localparam longint VMIN  = -64'sd2147483648;
  localparam int STALL_CAP = 20000000;
  localparam logic [1:0] ACT_IGNORED = 2'd3;
  localparam int BIG_LOADS = 200;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  in_t        cmd = '0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_data = 7'd4;
  logic       strobe;
  out_t       result;

  distance_matrix_additive_fill dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .strobe(strobe), .result(result)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // predictor state: our own copy of the matrix, pointers and size register
  // ---------------------------------------------------------------------
  longint     dm_val [TAXA_CAP*TAXA_CAP];
  bit         dm_ok  [TAXA_CAP*TAXA_CAP];
  logic [6:0] size_reg = 7'd4;
  longint     largest = 0;
  int         load_ptr = 0;
  int         read_ptr = 0;

  in_t  pending_cmds [$];   // command beats waiting for the driver
  out_t expected_res [$];   // results predicted from accepted beats
  int   errors = 0;

  // effective taxa count, clamped to the legal range
  function automatic int taxa_count();
    int n;
    n = size_reg;
    if (n < 2) n = 2;
    if (n > TAXA_CAP) n = TAXA_CAP;
    return n;
  endfunction

  function automatic longint sat32(longint x);
    if (x > VMAX) return VMAX;
    if (x < VMIN) return VMIN;
    return x;
  endfunction

  function automatic bit cell_known(int a, int b);
    if (a == b) return 1'b1;
    return dm_ok[a*TAXA_CAP + b];
  endfunction

  function automatic longint cell_value(int a, int b);
    if (a == b) return 0;
    return dm_val[a*TAXA_CAP + b];
  endfunction

  task automatic put_pair(int a, int b, longint v, bit ok);
    dm_val[a*TAXA_CAP + b] = v;
    dm_ok[a*TAXA_CAP + b]  = ok;
    dm_val[b*TAXA_CAP + a] = v;
    dm_ok[b*TAXA_CAP + a]  = ok;
  endtask

  // in-place four-point sweeps, repeated until a sweep changes nothing
  task automatic fill_sweeps(int n);
    bit     changed;
    bit     found;
    longint best, sa, sb, m;
    do begin
      changed = 1'b0;
      for (int i = 0; i + 1 < n; i++) begin
        for (int j = i + 1; j < n; j++) begin
          if (!cell_known(i, j)) begin
            best  = largest;
            found = 1'b0;
            for (int k = 0; k < n; k++) begin
              if (cell_known(i, k) && cell_known(j, k)) begin
                for (int l = 0; l < n; l++) begin
                  if (k != l && cell_known(k, l) && cell_known(i, l) && cell_known(j, l)) begin
                    found = 1'b1;
                    sa = sat32(cell_value(i, k) + cell_value(j, l));
                    sb = sat32(cell_value(i, l) + cell_value(j, k));
                    m  = sat32((sa > sb ? sa : sb) - cell_value(k, l));
                    if (m < best) best = m;
                  end
                end
              end
            end
            if (found) begin
              put_pair(i, j, best, 1'b1);
              changed = 1'b1;
            end
          end
        end
      end
    end while (changed);
  endtask

  // apply one accepted command beat and queue whatever result it causes
  task automatic apply_command(in_t c);
    int   n, pairs, p, row, r, total;
    bit   ok;
    out_t e;
    n = taxa_count();
    e = '0;
    case (c.action)
      ACT_LOAD: begin
        pairs = n * (n - 1) / 2;
        ok = !c.dist_missing;
        if (load_ptr >= pairs) load_ptr = 0;
        p = load_ptr;
        r = 0;
        row = n - 1;
        while (p >= row) begin
          p -= row;
          r++;
          row--;
        end
        put_pair(r, r + 1 + p, longint'(c.dist_value), ok);
        if (load_ptr == 0) largest = ok ? longint'(c.dist_value) : 0;
        else if (ok && longint'(c.dist_value) > largest) largest = longint'(c.dist_value);
        load_ptr++;
        if (load_ptr >= pairs) load_ptr = 0;
      end
      ACT_FILL: begin
        fill_sweeps(n);
        read_ptr = 0;
        e.fill_done = 1'b1;
        expected_res.push_back(e);
      end
      ACT_READ: begin
        total = n * n;
        if (read_ptr >= total) read_ptr = 0;
        e.out_value = 32'(cell_value(read_ptr / n, read_ptr % n));
        e.out_valid = cell_known(read_ptr / n, read_ptr % n);
        e.out_last  = (read_ptr == total - 1);
        read_ptr++;
        if (read_ptr >= total) read_ptr = 0;
        expected_res.push_back(e);
      end
      default: begin
        // unused action: no result
      end
    endcase
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  // gap before the next beat: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------
  // driver: takes beats from the pending queue, random gaps between them
  // ---------------------------------------------------------------------
  int gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap   <= 0;
    end else begin
      if (start && !busy) apply_command(cmd);
      // hold the beat while the block is busy, otherwise move on
      if (!(start && busy)) begin
        if (gap > 0) begin
          gap   <= gap - 1;
          start <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cmd   <= pending_cmds.pop_front();
          start <= 1'b1;
          gap   <= pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // monitor: every strobe beat against the oldest prediction
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    out_t e;
    if (!rst && strobe) begin
      if (expected_res.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        e = expected_res.pop_front();
        if (result.out_value !== e.out_value)
          report_mismatch($sformatf("out_value %h, expected %h", result.out_value, e.out_value));
        if (result.out_valid !== e.out_valid)
          report_mismatch($sformatf("out_valid %b, expected %b", result.out_valid, e.out_valid));
        if (result.out_last !== e.out_last)
          report_mismatch($sformatf("out_last %b, expected %b", result.out_last, e.out_last));
        if (result.fill_done !== e.fill_done)
          report_mismatch($sformatf("fill_done %b, expected %b", result.fill_done, e.fill_done));
      end
    end
  end

  // watchdog: cycles with no beat moving on any channel
  int quiet = 0;

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet + 1 >= STALL_CAP) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------

  // wait until the block has drained, then give a trailing load time to land
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || start || gap != 0 || expected_res.size() != 0);
    repeat (12) @(negedge clk);
  endtask

  task automatic set_size(logic [6:0] v);
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_reg = v;
  endtask

  function automatic in_t make_beat(logic [1:0] act, logic [30:0] v, bit miss);
    in_t b;
    b.action       = act;
    b.dist_value   = v;
    b.dist_missing = miss;
    return b;
  endfunction

  // distances: full random, small, or close to the top of the range
  function automatic logic [30:0] rand_dist();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 31'($urandom);
    if (r < 8) return 31'($urandom_range(0, 32'h000a_0000));
    return 31'h7fff_ffff - 31'($urandom_range(0, 255));
  endfunction

  // one beat per pair covers every cell of the current size from any pointer
  task automatic push_full_load(int n, int miss_pct);
    for (int p = 0; p < n * (n - 1) / 2; p++)
      pending_cmds.push_back(make_beat(ACT_LOAD, rand_dist(),
                                       $urandom_range(0, 99) < miss_pct));
  endtask

  initial begin
    int       counted, n, len, r, miss_pct;
    int       sizes [$];
    logic [6:0] sz;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: three taxa, zero, top of range, a missing pair, unused action, reads, fill
    set_size(7'd3);
    pending_cmds.push_back(make_beat(ACT_LOAD, 31'h7fff_ffff, 1'b0));
    pending_cmds.push_back(make_beat(ACT_LOAD, 31'h0000_0000, 1'b1));
    pending_cmds.push_back(make_beat(ACT_LOAD, 31'h7fff_ffff, 1'b0));
    pending_cmds.push_back(make_beat(ACT_IGNORED, 31'h5555_5555, 1'b1));
    for (int i = 0; i < 9; i++) pending_cmds.push_back(make_beat(ACT_READ, '0, 1'b0));
    pending_cmds.push_back(make_beat(ACT_FILL, '0, 1'b0));
    for (int i = 0; i < 9; i++) pending_cmds.push_back(make_beat(ACT_READ, '0, 1'b0));

    // size extremes first (clamped below two and above the cap), then small sizes
    sizes = '{0, 1, 2, 127, 64};
    counted = 0;
    while (counted < 950) begin
      if (sizes.size() != 0) sz = 7'(sizes.pop_front());
      else sz = 7'($urandom_range(3, 12));
      set_size(sz);
      n = taxa_count();
      if (n == TAXA_CAP) begin
        // big matrix: load only part of the pairs and read a stretch of cells, no fill
        for (int p = 0; p < BIG_LOADS; p++)
          pending_cmds.push_back(make_beat(ACT_LOAD, rand_dist(),
                                           $urandom_range(0, 99) < 20));
        len = $urandom_range(40, 80);
        for (int i = 0; i < len; i++) pending_cmds.push_back(make_beat(ACT_READ, '0, 1'b0));
        counted += len + BIG_LOADS;
      end else begin
        miss_pct = $urandom_range(0, 60);
        push_full_load(n, miss_pct);
        counted += n * (n - 1) / 2;
        len = $urandom_range(20, 90);
        for (int i = 0; i < len; i++) begin
          r = $urandom_range(0, 99);
          if (r < 30)
            pending_cmds.push_back(make_beat(ACT_LOAD, rand_dist(),
                                             $urandom_range(0, 99) < miss_pct));
          else if (r < 42) pending_cmds.push_back(make_beat(ACT_FILL, 31'($urandom), 1'b0));
          else if (r < 95) pending_cmds.push_back(make_beat(ACT_READ, 31'($urandom), 1'b1));
          else pending_cmds.push_back(make_beat(ACT_IGNORED, 31'($urandom), 1'b0));
          if (r < 95) counted++;
        end
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (expected_res.size() != 0) report_mismatch("expected results left over");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
